// ===== src/mlfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and codes of the feedback queue scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

   typedef enum logic [1:0] {
      OP_SUBMIT   = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_TICK     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_SUBMITTED = 3'd0,
      ST_REQUEUED  = 3'd1,
      ST_FINISHED  = 3'd2,
      ST_IDLE      = 3'd3,
      ST_REJECTED  = 3'd4,
      ST_TICK      = 3'd5
   } status_type;

   localparam logic [1:0] CSR_BOOST_PERIOD = 2'd0;
   localparam logic [1:0] CSR_QUANTUM      = 2'd1;
   localparam logic [1:0] CSR_LEVEL_SPAN   = 2'd2;

   localparam int LEVELS      = 4;
   localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
   localparam logic [15:0] TOTAL_MAX   = 16'hFFFF;

endpackage

// ===== src/mlfq_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_task_scheduler_core
// four-level feedback queue scheduler over a table of task slots
// ----------------------------------------------------------------------------
// flow: tick, submit and rejected words pass S_DECODE and S_DONE; a dispatch runs
//   S_DECODE, S_PICK, S_READ, S_GRANT, S_PUSH, S_DONE (idle: S_DECODE, S_PICK, S_DONE);
//   a priority boost drains levels 1 to 3, S_BOOST_RD then S_BOOST_MV per task moved
// throughput: one word at a time; req_tready is low while a word is worked on
//   or its result waits in the output register
// reset: synchronous, queues empty, all slots free, elapsed zero, registers at
//   their documented defaults; the slot tables need no clearing
module mlfq_task_scheduler_core
   import mlfq_pkg::*;
#(
   parameter int NUM_TASKS = 32
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], task_id[6:2], task_length[22:7], io_odds[29:23],
   // random_percent[36:30], random_slice[42:37]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], run_task[7:3], slice[15:8], new_level[17:16],
   // remaining[33:18], boosted[34]
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CW = $clog2(NUM_TASKS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_BOOST_RD, S_BOOST_MV, S_PICK, S_READ, S_GRANT,
      S_PUSH, S_DONE
   } state_type;

   state_type   state_ff;
   logic [47:0] req_ff;
   logic [19:0] boost_period_ff;
   logic [7:0]  quantum_ff;
   logic [11:0] level_span_ff;
   logic [19:0] elapsed_ff;
   logic [SW-1:0] head_ff  [LEVELS];
   logic [SW-1:0] tail_ff  [LEVELS];
   logic [CW-1:0] count_ff [LEVELS];
   logic [NUM_TASKS-1:0] busy_ff;
   // slot tables, single clocked write and registered read
   logic [SW-1:0] link_mem  [NUM_TASKS];
   logic [15:0]   work_mem  [NUM_TASKS];
   logic [15:0]   total_mem [NUM_TASKS];
   logic [6:0]    odds_mem  [NUM_TASKS];
   logic [SW-1:0] link_rd_ff;
   logic [15:0]   work_rd_ff;
   logic [15:0]   total_rd_ff;
   logic [6:0]    odds_rd_ff;

   logic [1:0]    blvl_ff;     // level drained by the boost
   logic [1:0]    dlvl_ff;     // level popped by the dispatch
   logic [SW-1:0] slot_ff;
   logic          boosted_ff;
   logic [7:0]    slice_ff;
   logic [15:0]   rem_ff;
   logic [15:0]   tot_ff;
   logic          rsp_valid_ff;
   logic [39:0]   rsp_data_ff;

   // held request fields used by submit and grant
   logic [SW-1:0] sub_slot;
   logic [6:0]    rpct_q;
   logic [5:0]    rslice_q;
   assign sub_slot = SW'(req_ff[6:2]);
   assign rpct_q   = req_ff[36:30];
   assign rslice_q = req_ff[42:37];

   // level compare against the new run total
   logic [1:0] pick_lvl;
   mlfq_level_pick u_pick (.total(tot_ff), .span(level_span_ff), .level(pick_lvl));

   // grant arithmetic on registered table reads
   logic [7:0]  cap;
   logic [15:0] slice_w;
   logic [16:0] tsum;
   assign cap     = (rpct_q <= odds_rd_ff) ? {2'b00, rslice_q} : quantum_ff;
   assign slice_w = (work_rd_ff < {8'd0, cap}) ? work_rd_ff : {8'd0, cap};
   assign tsum    = {1'b0, total_rd_ff} + {1'b0, slice_w};

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   logic [SW-1:0] rd_addr;
   always_comb begin
      case (state_ff)
         S_BOOST_RD: rd_addr = head_ff[blvl_ff];
         default:    rd_addr = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      link_rd_ff  <= link_mem[rd_addr];
      work_rd_ff  <= work_mem[rd_addr];
      total_rd_ff <= total_mem[rd_addr];
      odds_rd_ff  <= odds_mem[rd_addr];
   end

   function automatic logic [39:0] pack(status_type st, logic [4:0] t, logic [7:0] sl,
                                        logic [1:0] lv, logic [15:0] rm, logic b);
      return {5'd0, b, rm, lv, sl, t, st};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         boost_period_ff <= 20'd1000;
         quantum_ff      <= 8'd50;
         level_span_ff   <= 12'd200;
         elapsed_ff      <= '0;
         busy_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BOOST_PERIOD: boost_period_ff <= csr_wdata;
               CSR_QUANTUM:      quantum_ff      <= csr_wdata[7:0];
               CSR_LEVEL_SPAN:   level_span_ff   <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  req_ff   <= req_tdata;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               boosted_ff <= 1'b0;
               blvl_ff    <= 2'd1;
               state_ff   <= S_DONE;
               case (op_type'(req_ff[1:0]))
                  OP_SUBMIT: begin
                     if ({{(32-5){1'b0}}, req_ff[6:2]} < NUM_TASKS
                         && !busy_ff[sub_slot]) begin
                        busy_ff[sub_slot]   <= 1'b1;
                        work_mem[sub_slot]  <= req_ff[22:7];
                        total_mem[sub_slot] <= '0;
                        odds_mem[sub_slot]  <= req_ff[29:23];
                        if (count_ff[0] == '0) head_ff[0] <= sub_slot;
                        else link_mem[tail_ff[0]] <= sub_slot;
                        tail_ff[0]  <= sub_slot;
                        count_ff[0] <= count_ff[0] + 1'b1;
                        rsp_data_ff <= pack(ST_SUBMITTED, req_ff[6:2], '0, '0,
                                            req_ff[22:7], 1'b0);
                     end else begin
                        rsp_data_ff <= pack(ST_REJECTED, req_ff[6:2], '0, '0, '0, 1'b0);
                     end
                  end
                  OP_DISPATCH: begin
                     if (elapsed_ff >= boost_period_ff) begin
                        boosted_ff <= 1'b1;
                        elapsed_ff <= '0;
                        state_ff   <= S_BOOST_RD;
                     end else begin
                        state_ff <= S_PICK;
                     end
                  end
                  OP_TICK: begin
                     if (elapsed_ff != ELAPSED_MAX) elapsed_ff <= elapsed_ff + 1'b1;
                     rsp_data_ff <= pack(ST_TICK, '0, '0, '0, '0, 1'b0);
                  end
                  default: rsp_data_ff <= pack(ST_REJECTED, '0, '0, '0, '0, 1'b0);
               endcase
            end
            S_BOOST_RD: begin
               // one level drained head first, link read registered
               if (count_ff[blvl_ff] == '0) begin
                  if (blvl_ff == 2'd3) state_ff <= S_PICK;
                  else blvl_ff <= blvl_ff + 2'd1;
               end else begin
                  slot_ff  <= head_ff[blvl_ff];
                  state_ff <= S_BOOST_MV;
               end
            end
            S_BOOST_MV: begin
               if (count_ff[blvl_ff] > 1) head_ff[blvl_ff] <= link_rd_ff;
               count_ff[blvl_ff]  <= count_ff[blvl_ff] - 1'b1;
               total_mem[slot_ff] <= '0;
               if (count_ff[0] == '0) head_ff[0] <= slot_ff;
               else link_mem[tail_ff[0]] <= slot_ff;
               tail_ff[0]  <= slot_ff;
               count_ff[0] <= count_ff[0] + 1'b1;
               state_ff    <= S_BOOST_RD;
            end
            S_PICK: begin
               if (count_ff[0] != '0) begin
                  dlvl_ff <= 2'd0; slot_ff <= head_ff[0]; state_ff <= S_READ;
               end else if (count_ff[1] != '0) begin
                  dlvl_ff <= 2'd1; slot_ff <= head_ff[1]; state_ff <= S_READ;
               end else if (count_ff[2] != '0) begin
                  dlvl_ff <= 2'd2; slot_ff <= head_ff[2]; state_ff <= S_READ;
               end else if (count_ff[3] != '0) begin
                  dlvl_ff <= 2'd3; slot_ff <= head_ff[3]; state_ff <= S_READ;
               end else begin
                  rsp_data_ff <= pack(ST_IDLE, '0, '0, '0, '0, boosted_ff);
                  state_ff    <= S_DONE;
               end
            end
            S_READ: state_ff <= S_GRANT;
            S_GRANT: begin
               if (count_ff[dlvl_ff] > 1) head_ff[dlvl_ff] <= link_rd_ff;
               count_ff[dlvl_ff] <= count_ff[dlvl_ff] - 1'b1;
               slice_ff <= slice_w[7:0];
               rem_ff   <= work_rd_ff - slice_w;
               tot_ff   <= tsum[16] ? TOTAL_MAX : tsum[15:0];
               work_mem[slot_ff]  <= work_rd_ff - slice_w;
               total_mem[slot_ff] <= tsum[16] ? TOTAL_MAX : tsum[15:0];
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (rem_ff == '0) begin
                  busy_ff[slot_ff] <= 1'b0;
                  rsp_data_ff <= pack(ST_FINISHED, 5'(slot_ff), slice_ff, '0, rem_ff,
                                      boosted_ff);
               end else begin
                  if (count_ff[pick_lvl] == '0) head_ff[pick_lvl] <= slot_ff;
                  else link_mem[tail_ff[pick_lvl]] <= slot_ff;
                  tail_ff[pick_lvl]  <= slot_ff;
                  count_ff[pick_lvl] <= count_ff[pick_lvl] + 1'b1;
                  rsp_data_ff <= pack(ST_REQUEUED, 5'(slot_ff), slice_ff, pick_lvl,
                                      rem_ff, boosted_ff);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== src/mlfq_level_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_level_pick
// chooses the requeue level from a run total and the level span
// ----------------------------------------------------------------------------
module mlfq_level_pick
   import mlfq_pkg::*;
(
   input  logic [15:0] total,
   input  logic [11:0] span,
   output logic [1:0]  level
);
   logic [13:0] span2;
   logic [13:0] span3;

   assign span2 = {1'b0, span, 1'b0};
   assign span3 = span2 + {2'b00, span};

   always_comb begin
      if (total <= {4'd0, span})
         level = 2'd0;
      else if (total > {2'd0, span3})
         level = 2'd3;
      else if (total > {2'd0, span2})
         level = 2'd2;
      else
         level = 2'd1;
   end
endmodule

// ===== src/mlfq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
module mlfq_checker
   import mlfq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   // no new word while a result waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while result pending");
   // an accepted word blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");
   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");
   // status is a defined code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= 3'd5)) else $error("bad status");
endmodule

bind mlfq_task_scheduler_core mlfq_checker u_mlfq_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// randomised stream test of the feedback queue scheduler against a predictor
// ----------------------------------------------------------------------------
module testbench;
   import mlfq_pkg::*;

   // most significant field first, so status sits in the lowest bits
   typedef struct packed {
      logic        boosted;
      logic [15:0] remaining;
      logic [1:0]  new_level;
      logic [7:0]  slice;
      logic [4:0]  run_task;
      logic [2:0]  status;
   } sched_result;

   // scoreboard holding predicted scheduler results in arrival order
   class result_board;
      sched_result pending[$];
      int errors;

      function void note(sched_result r);
         pending.push_back(r);
      endfunction

      function void check(sched_result got);
         sched_result exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (exp_r.status !== got.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
         end
         if (exp_r.run_task !== got.run_task) begin
            $display("%0t: run_task expected %0d actual %0d", $time, exp_r.run_task,
               got.run_task);
            errors++;
         end
         if (exp_r.slice !== got.slice) begin
            $display("%0t: slice expected %0d actual %0d", $time, exp_r.slice, got.slice);
            errors++;
         end
         if (exp_r.new_level !== got.new_level) begin
            $display("%0t: new_level expected %0d actual %0d", $time, exp_r.new_level,
               got.new_level);
            errors++;
         end
         if (exp_r.remaining !== got.remaining) begin
            $display("%0t: remaining expected %0d actual %0d", $time, exp_r.remaining,
               got.remaining);
            errors++;
         end
         if (exp_r.boosted !== got.boosted) begin
            $display("%0t: boosted expected %0d actual %0d", $time, exp_r.boosted,
               got.boosted);
            errors++;
         end
      endfunction
   endclass

   localparam int MAX_CYCLES = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_wdata = '0;

   result_board board;
   int unsigned cycle_count = 0;

   // predictor state
   logic [4:0]  lv_head [4];
   logic [4:0]  lv_tail [4];
   int unsigned lv_count [4];
   logic [4:0]  link_of [32];
   logic [15:0] work_of [32];
   logic [15:0] total_of [32];
   logic [6:0]  odds_of [32];
   logic        busy_of [32];
   logic [19:0] ticks;
   logic [19:0] cfg_boost;
   logic [7:0]  cfg_quantum;
   logic [11:0] cfg_span;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   mlfq_task_scheduler_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic void enqueue(int lvl, logic [4:0] s);
      if (lv_count[lvl] == 0) lv_head[lvl] = s;
      else link_of[lv_tail[lvl]] = s;
      lv_tail[lvl] = s;
      lv_count[lvl]++;
   endfunction

   function automatic logic [4:0] dequeue(int lvl);
      logic [4:0] s;
      s = lv_head[lvl];
      if (lv_count[lvl] > 1) lv_head[lvl] = link_of[s];
      lv_count[lvl]--;
      return s;
   endfunction

   function automatic logic [1:0] level_for(logic [15:0] total);
      int unsigned span;
      span = cfg_span;
      if (total <= span) return 2'd0;
      if (total > 3 * span) return 2'd3;
      if (total > 2 * span) return 2'd2;
      return 2'd1;
   endfunction

   // work out the scheduler's answer to one word and update the copy
   function automatic sched_result schedule_word(logic [47:0] w);
      sched_result r;
      logic [1:0]  op;
      logic [4:0]  id, s;
      logic [15:0] len;
      logic [6:0]  odds, rpct;
      logic [5:0]  rslice;
      int unsigned cap, sl, t;
      op = w[1:0]; id = w[6:2]; len = w[22:7]; odds = w[29:23];
      rpct = w[36:30]; rslice = w[42:37];
      r = '0;
      r.status = ST_REJECTED;
      if (op == OP_SUBMIT) begin
         r.run_task = id;
         if (!busy_of[id]) begin
            busy_of[id] = 1'b1;
            work_of[id] = len;
            total_of[id] = '0;
            odds_of[id] = odds;
            enqueue(0, id);
            r.status = ST_SUBMITTED;
            r.remaining = len;
         end
      end else if (op == OP_DISPATCH) begin
         if (ticks >= cfg_boost) begin
            // priority boost: drain lower levels into the top one
            for (int l = 1; l < 4; l++)
               while (lv_count[l] > 0) begin
                  s = dequeue(l);
                  total_of[s] = '0;
                  enqueue(0, s);
               end
            ticks = '0;
            r.boosted = 1'b1;
         end
         r.status = ST_IDLE;
         for (int l = 0; l < 4; l++)
            if (lv_count[l] > 0) begin
               s = dequeue(l);
               cap = (rpct <= odds_of[s]) ? rslice : cfg_quantum;
               sl = (work_of[s] < cap) ? work_of[s] : cap;
               work_of[s] = 16'(work_of[s] - sl);
               t = total_of[s] + sl;
               total_of[s] = (t > 65535) ? 16'hFFFF : t[15:0];
               r.run_task = s;
               r.slice = sl[7:0];
               r.remaining = work_of[s];
               if (work_of[s] == 0) begin
                  busy_of[s] = 1'b0;
                  r.status = ST_FINISHED;
               end else begin
                  r.new_level = level_for(total_of[s]);
                  enqueue(r.new_level, s);
                  r.status = ST_REQUEUED;
               end
               break;
            end
      end else if (op == OP_TICK) begin
         if (ticks != ELAPSED_MAX) ticks++;
         r.status = ST_TICK;
      end
      return r;
   endfunction

   function automatic logic [47:0] pack_word(logic [1:0] op, logic [4:0] id, logic [15:0] len,
         logic [6:0] odds, logic [6:0] rpct, logic [5:0] rslice);
      return {5'd0, rslice, rpct, odds, len, id, op};
   endfunction

   // send one word, sometimes after a random gap when a burst ends
   int burst_left = 0;
   task automatic send_word(logic [47:0] w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note(schedule_word(w));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [19:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BOOST_PERIOD: cfg_boost = val;
         CSR_QUANTUM:      cfg_quantum = val[7:0];
         CSR_LEVEL_SPAN:   cfg_span = val[11:0];
         default: ;
      endcase
   endtask

   // random word: mostly submits of random slots and dispatches, some ticks and invalid words
   task automatic random_word();
      int pick;
      logic [4:0] id;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      id = 5'($urandom_range(0, 31));
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      if (pick < 35)
         send_word(pack_word(OP_SUBMIT, id, len, 7'($urandom_range(0, 100)),
            7'($urandom_range(0, 100)), 6'($urandom_range(0, 50))));
      else if (pick < 80)
         send_word(pack_word(OP_DISPATCH, id, len, 7'($urandom_range(0, 127)),
            7'($urandom_range(0, 100)), 6'($urandom_range(0, 50))));
      else if (pick < 97)
         send_word(pack_word(OP_TICK, id, len, 7'($urandom), 7'($urandom), 6'($urandom)));
      else
         send_word(pack_word(OP_NONE, id, len, 7'($urandom), 7'($urandom), 6'($urandom)));
   endtask

   // receiver: stall pattern alternates quiet and choppy stretches
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase = (phase + 1) % 200;
         if (phase < 60) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 40) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check(sched_result'(rsp_tdata[34:0]));
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("FAIL mlfq_task_scheduler_core");
         $finish;
      end
   end

   initial begin
      board = new();
      for (int l = 0; l < 4; l++) begin
         lv_head[l] = '0; lv_tail[l] = '0; lv_count[l] = 0;
      end
      for (int i = 0; i < 32; i++) begin
         link_of[i] = '0; work_of[i] = '0; total_of[i] = '0;
         odds_of[i] = '0; busy_of[i] = 1'b0;
      end
      ticks = '0; cfg_boost = 20'd1000; cfg_quantum = 8'd50; cfg_span = 12'd200;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty dispatch, field extremes, rejects, zero length
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd0, 6'd0));
      send_word(pack_word(OP_SUBMIT, 5'd0, 16'd0, 7'd0, 7'd100, 6'd50));
      send_word(pack_word(OP_SUBMIT, 5'd31, 16'hFFFF, 7'd100, 7'd0, 6'd0));
      send_word(pack_word(OP_SUBMIT, 5'd31, 16'd5, 7'd5, 7'd0, 6'd0));
      send_word(pack_word(OP_SUBMIT, 5'd7, 16'd120, 7'd127, 7'd0, 6'd0));
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd100, 6'd50));
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd127, 6'd63));
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd0, 6'd63));
      send_word(pack_word(OP_TICK, 5'd31, 16'hFFFF, 7'd127, 7'd127, 6'd63));
      send_word(pack_word(OP_NONE, 5'd31, 16'hFFFF, 7'd127, 7'd127, 6'd63));
      send_word(pack_word(OP_NONE, 5'd0, 16'd0, 7'd0, 7'd0, 6'd0));
      // pause until everything is answered
      drain();
      // zero quantum and zero span, then an immediate boost
      write_reg(CSR_QUANTUM, 20'd0);
      write_reg(CSR_LEVEL_SPAN, 20'd0);
      write_reg(CSR_BOOST_PERIOD, 20'd0);
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd100, 6'd0));
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd0, 6'd33));
      send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd101, 6'd10));
      drain();
      write_reg(CSR_QUANTUM, 20'd255);
      write_reg(CSR_LEVEL_SPAN, 20'd4095);
      write_reg(CSR_BOOST_PERIOD, 20'hFFFFF);
      for (int i = 0; i < 6; i++)
         send_word(pack_word(OP_DISPATCH, 5'd0, 16'd0, 7'd0, 7'd120, 6'd0));
      drain();

      // random phases over several settings
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               write_reg(CSR_BOOST_PERIOD, 20'd1000);
               write_reg(CSR_QUANTUM, 20'd50);
               write_reg(CSR_LEVEL_SPAN, 20'd200);
            end
            1: begin
               write_reg(CSR_BOOST_PERIOD, 20'd3);
               write_reg(CSR_QUANTUM, 20'd1);
               write_reg(CSR_LEVEL_SPAN, 20'd1);
            end
            2: begin
               write_reg(CSR_BOOST_PERIOD, 20'd0);
               write_reg(CSR_QUANTUM, 20'd255);
               write_reg(CSR_LEVEL_SPAN, 20'd0);
            end
            3: begin
               write_reg(CSR_BOOST_PERIOD, 20'hFFFFF);
               write_reg(CSR_QUANTUM, 20'd0);
               write_reg(CSR_LEVEL_SPAN, 20'd4095);
            end
            default: begin
               write_reg(CSR_BOOST_PERIOD, 20'($urandom_range(0, 20)));
               write_reg(CSR_QUANTUM, 20'($urandom_range(1, 255)));
               write_reg(CSR_LEVEL_SPAN, 20'($urandom_range(1, 300)));
            end
         endcase
         for (int i = 0; i < 90; i++) random_word();
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) $display("PASS mlfq_task_scheduler_core");
      else $display("FAIL mlfq_task_scheduler_core");
      $finish;
   end

endmodule
